[rtl/core/tilt_to_position_tracker_unit_defines.svh]
// Assertion macros for the tilt-to-position tracker.
`ifndef TILT_TO_POSITION_TRACKER_UNIT_DEFINES_SVH
`define TILT_TO_POSITION_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TTP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TTP_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTP_ASSERT(label, clk, rstn, prop, msg)
`define TTP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/core/ttp_pkg.sv]
package ttp_pkg;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_Z  = 3'd5;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_A    = 2'd1;
    localparam logic [1:0] MODE_B    = 2'd2;
    localparam logic [1:0] MODE_ROT  = 2'd3;

    localparam logic [32:0] PI_Q30   = 33'd3373259426;
    localparam logic [32:0] C002_Q30 = 33'd21474836;
    localparam logic [32:0] C003_Q30 = 33'd32212255;
    localparam logic [32:0] C020_Q30 = 33'd214748365;
    localparam logic signed [31:0] INVK_Q30 = 32'sd652032875;

    // Datapath commands issued by the controller.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_DIV    = 3'd2;
    localparam logic [2:0] CMD_ROLL   = 3'd3;
    localparam logic [2:0] CMD_MAG    = 3'd4;
    localparam logic [2:0] CMD_PITCH  = 3'd5;
    localparam logic [2:0] CMD_APPLY  = 3'd6;
    localparam logic [2:0] CMD_BUTTON = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic       start;
    } ttp_cmd_t;

    typedef struct packed {
        logic is_button;
        logic span_zero;
        logic null_vec;
        logic done;
    } ttp_stat_t;

    function automatic logic [32:0] atan_q30(input int i);
        logic [32:0] t [TABLE_LEN];
        t = '{33'd843314857, 33'd497837830, 33'd263043837, 33'd133525159,
              33'd67021687, 33'd33543516, 33'd16775851, 33'd8388437,
              33'd4194283, 33'd2097149, 33'd1048576, 33'd524288,
              33'd262144, 33'd131072, 33'd65536, 33'd32768, 33'd16384,
              33'd8192, 33'd4096, 33'd2048, 33'd1024, 33'd512, 33'd256,
              33'd128};
        return t[i];
    endfunction

    function automatic logic [32:0] from_q30(input logic [32:0] c, input int f);
        logic [33:0] s;
        s = {1'b0, c} + (34'd1 << (29 - f));
        return s[33:1] >> (29 - f);
    endfunction
endpackage

[rtl/core/ttp_ctrl.sv]
module ttp_ctrl #(
    parameter int CORDIC_STEPS = ttp_pkg::CORDIC_STEPS_DEF,
    parameter int DIV_STEPS    = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ttp_pkg::ttp_cmd_t cmd,
    input  ttp_pkg::ttp_stat_t stat
);
    import ttp_pkg::*;
    `include "tilt_to_position_tracker_unit_defines.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ROLL  = 3'd2;
    localparam logic [2:0] ST_MAG   = 3'd3;
    localparam logic [2:0] ST_PITCH = 3'd4;
    localparam logic [2:0] ST_APPLY = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam int CNT_W = $clog2(DIV_STEPS + CORDIC_STEPS + 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        cmd        = '{op: CMD_NONE, start: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    cmd = '{op: CMD_LOAD, start: 1'b1};
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.is_button) begin
                    cmd = '{op: CMD_BUTTON, start: 1'b1};
                    state_next = ST_OUT;
                end else if (stat.span_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd = '{op: CMD_DIV, start: (cnt_reg == '0)};
                    if (stat.done) begin
                        cnt_next = '0;
                        state_next = ST_ROLL;
                    end
                end
            end
            ST_ROLL: begin
                if (stat.null_vec) begin
                    state_next = ST_OUT;
                end else begin
                    cmd = '{op: CMD_ROLL, start: (cnt_reg == '0)};
                    if (cnt_reg == CNT_W'(CORDIC_STEPS + 1)) begin
                        cnt_next = '0;
                        state_next = ST_MAG;
                    end
                end
            end
            ST_MAG: begin
                cmd = '{op: CMD_MAG, start: (cnt_reg == '0)};
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next = '0;
                    state_next = ST_PITCH;
                end
            end
            ST_PITCH: begin
                cmd = '{op: CMD_PITCH, start: (cnt_reg == '0)};
                if (cnt_reg == CNT_W'(CORDIC_STEPS + 1)) begin
                    cnt_next = '0;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd = '{op: CMD_APPLY, start: (cnt_reg == '0)};
                if (cnt_reg == CNT_W'(4)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `TTP_ASSERT(a_no_both, aclk, aresetn, !(s_ready && m_valid), "ready while result held")
    `TTP_ASSERT(a_hold_out, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `TTP_ASSERT(a_accept_leaves, aclk, aresetn, accept |=> !s_ready, "idle after accept")
endmodule

[rtl/core/ttp_datapath.sv]
module ttp_datapath #(
    parameter int FRAC_BITS    = ttp_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ttp_pkg::CORDIC_STEPS_DEF,
    parameter int DIV_STEPS    = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ttp_pkg::ttp_cmd_t                  cmd,
    output ttp_pkg::ttp_stat_t                 stat,
    input  logic                               cfg_we,
    input  logic [ttp_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [ttp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_opcode,
    input  logic [7:0]                         s_raw_x,
    input  logic [7:0]                         s_raw_y,
    input  logic [7:0]                         s_raw_z,
    input  logic [12:0]                        s_buttons,
    output logic signed [31:0]                 m_pos_x,
    output logic signed [31:0]                 m_pos_y,
    output logic signed [31:0]                 m_pos_z,
    output logic [1:0]                         m_mode
);
    import ttp_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int QW    = F + 5;
    localparam int CW    = F + 8;
    localparam int NW    = 9 + F;
    localparam int IW    = $clog2(CORDIC_STEPS + 1);
    localparam int DW    = $clog2(DIV_STEPS + 1);
    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam logic signed [CW-1:0] PI_F  = CW'(from_q30(PI_Q30, F));
    localparam logic signed [CW-1:0] C002  = CW'(from_q30(C002_Q30, F));
    localparam logic signed [CW-1:0] C003  = CW'(from_q30(C003_Q30, F));
    localparam logic signed [CW-1:0] C020  = CW'(from_q30(C020_Q30, F));
    localparam logic signed [CW-1:0] HALF  = CW'(1) <<< (F - 1);
    localparam logic signed [CW-1:0] LIM   = CW'(8) <<< F;

    logic [7:0] zero_reg [3];
    logic [7:0] one_reg  [3];
    logic [7:0] raw_reg  [3];
    logic [12:0] btn_reg;
    logic        op_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [1:0]         mode_reg;

    // Restoring divider, one quotient bit per cycle, three axes in parallel.
    logic [NW-1:0]       rem_reg [3];
    logic [NW-1:0]       quo_reg [3];
    logic [8:0]          den_reg [3];
    logic                neg_reg [3];
    logic signed [QW-1:0] a_reg [3];
    logic [DW-1:0]       dcnt_reg;

    // CORDIC unit.
    logic signed [CW+1:0] cx_reg, cy_reg, cz_reg;
    logic [IW-1:0]        ci_reg;
    logic signed [CW-1:0] roll_reg, pitch_reg;
    logic signed [CW-1:0] r0fix_reg;
    logic                 r0mode_reg;
    logic signed [CW+1:0] mag_reg;
    logic signed [63:0]   magp_reg;
    logic signed [2*CW+3:0] prod_reg;
    logic [1:0]           acnt_reg;
    logic signed [CW-1:0] apply_v;
    logic signed [CW-1:0] apply_c;
    logic                 apply_en, apply_neg;
    logic                 apply_en_reg, apply_neg_reg;
    logic [1:0]           apply_sel_reg;

    logic span_zero, null_vec;
    always_comb begin
        span_zero = (one_reg[0] == zero_reg[0]) || (one_reg[1] == zero_reg[1]) ||
                    (one_reg[2] == zero_reg[2]);
        null_vec  = (a_reg[0] == '0) && (a_reg[2] == '0);
        stat.is_button = op_reg;
        stat.span_zero = span_zero;
        stat.null_vec  = null_vec;
        stat.done      = (dcnt_reg == DW'(DIV_STEPS));
    end

    function automatic logic signed [31:0] sat_add_w(input logic signed [31:0] p,
                                                     input logic signed [CW+2:0] d);
        logic signed [CW+34:0] s;
        s = (CW+35)'(p) + (CW+35)'(d);
        if (s > (CW+35)'(64'sh7fffffff)) return 32'sh7fffffff;
        if (s < -(CW+35)'(64'sh80000000)) return 32'sh80000000;
        return s[31:0];
    endfunction

    logic signed [CW+1:0] dxs, dys;
    logic signed [CW-1:0] tstep;
    always_comb begin
        dxs   = cy_reg >>> ci_reg;
        dys   = cx_reg >>> ci_reg;
        tstep = CW'(from_q30(atan_q30(int'(ci_reg)), F));
    end

    logic signed [2*CW+3:0] rounded;
    logic signed [CW+2:0]   delta;
    always_comb begin
        rounded = (prod_reg + ((2*CW+4)'(1) <<< (F - 1))) >>> F;
        delta   = (CW+3)'(rounded);
        if (apply_neg_reg) delta = -delta;
    end

    always_comb begin
        apply_en = 1'b0;
        apply_neg = 1'b0;
        apply_v = '0;
        apply_c = C002;
        case (acnt_reg)
            2'd0: begin
                apply_c = C002;
                apply_neg = 1'b1;
                if (roll_reg > HALF) begin
                    apply_en = 1'b1; apply_v = roll_reg - HALF;
                end else if (roll_reg < -HALF) begin
                    apply_en = 1'b1; apply_v = roll_reg + HALF;
                end
            end
            2'd1: begin
                apply_c = C003;
                apply_neg = 1'b1;
                if (pitch_reg > HALF) begin
                    apply_en = 1'b1; apply_v = pitch_reg - HALF;
                end else if (pitch_reg < -HALF) begin
                    apply_en = 1'b1; apply_v = pitch_reg + HALF;
                end
            end
            2'd2: begin
                apply_c = C002;
                if (CW'(a_reg[0]) > C020) begin
                    apply_en = 1'b1; apply_v = CW'(a_reg[0]) - C020;
                end else if (CW'(a_reg[0]) < -C020) begin
                    apply_en = 1'b1; apply_v = CW'(a_reg[0]) + C020;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                zero_reg[k] <= 8'd128;
                one_reg[k]  <= 8'd154;
            end
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_ZERO_X: zero_reg[0] <= cfg_data;
                REG_ZERO_Y: zero_reg[1] <= cfg_data;
                REG_ZERO_Z: zero_reg[2] <= cfg_data;
                REG_ONE_X:  one_reg[0]  <= cfg_data;
                REG_ONE_Y:  one_reg[1]  <= cfg_data;
                REG_ONE_Z:  one_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [NW-1:0] trial [3];
    logic [NW-1:0] shr   [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            shr[k]   = {rem_reg[k][NW-2:0], quo_reg[k][NW-1]};
            trial[k] = shr[k] - NW'(den_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg   <= '0;
            py_reg   <= '0;
            pz_reg   <= '0;
            mode_reg <= MODE_NONE;
            op_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                CMD_LOAD: begin
                    op_reg     <= s_opcode;
                    raw_reg[0] <= s_raw_x;
                    raw_reg[1] <= s_raw_y;
                    raw_reg[2] <= s_raw_z;
                    btn_reg    <= s_buttons;
                    dcnt_reg   <= '0;
                end
                CMD_BUTTON: begin : btn_blk
                    logic signed [31:0] x, y, z;
                    logic [1:0] m;
                    x = px_reg; y = py_reg; z = pz_reg; m = mode_reg;
                    if (btn_reg[11]) y = sat_add_w(y, (CW+3)'(C020));
                    if (btn_reg[10]) y = sat_add_w(y, -(CW+3)'(C020));
                    if (btn_reg[9])  x = sat_add_w(x, (CW+3)'(C020));
                    if (btn_reg[8])  x = sat_add_w(x, -(CW+3)'(C020));
                    if (btn_reg[12]) z = sat_add_w(z, (CW+3)'(C020));
                    if (btn_reg[4])  z = sat_add_w(z, -(CW+3)'(C020));
                    if (btn_reg[3]) m = MODE_A;
                    if (btn_reg[2]) m = MODE_B;
                    if (btn_reg[7]) m = MODE_NONE;
                    if (btn_reg[1]) m = MODE_ROT;
                    if (btn_reg[0]) m = MODE_NONE;
                    px_reg <= x; py_reg <= y; pz_reg <= z; mode_reg <= m;
                end
                CMD_DIV: begin
                    if (cmd.start) begin
                        for (int k = 0; k < 3; k++) begin : dinit
                            logic signed [9:0] n, d;
                            logic [9:0] an, ad;
                            n  = 10'(signed'({2'b0, raw_reg[k]})) -
                                 10'(signed'({2'b0, zero_reg[k]}));
                            d  = 10'(signed'({2'b0, one_reg[k]})) -
                                 10'(signed'({2'b0, zero_reg[k]}));
                            an = n[9] ? -n : n;
                            ad = d[9] ? -d : d;
                            rem_reg[k] <= '0;
                            quo_reg[k] <= NW'(an[8:0]) << F;
                            den_reg[k] <= ad[8:0];
                            neg_reg[k] <= n[9] ^ d[9];
                        end
                        dcnt_reg <= '0;
                    end else if (dcnt_reg < DW'(NW)) begin
                        for (int k = 0; k < 3; k++) begin
                            if (!trial[k][NW-1] || shr[k] >= NW'(den_reg[k])) begin
                                rem_reg[k] <= shr[k] - NW'(den_reg[k]);
                                quo_reg[k] <= {quo_reg[k][NW-2:0], 1'b1};
                            end else begin
                                rem_reg[k] <= shr[k];
                                quo_reg[k] <= {quo_reg[k][NW-2:0], 1'b0};
                            end
                        end
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end else begin
                        for (int k = 0; k < 3; k++) begin : dfin
                            logic [NW-1:0] q;
                            q = quo_reg[k];
                            if (!neg_reg[k]) begin
                                a_reg[k] <= (q > NW'(LIM - 1)) ? QW'(LIM - 1) : QW'(q);
                            end else begin
                                a_reg[k] <= (q > NW'(LIM)) ? -QW'(LIM) : -QW'(q);
                            end
                        end
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                CMD_ROLL, CMD_PITCH: begin
                    if (cmd.start) begin
                        ci_reg <= '0;
                        cz_reg <= '0;
                        if (cmd.op == CMD_PITCH) begin
                            cx_reg <= (CW+2)'(magp_reg);
                            cy_reg <= (CW+2)'(a_reg[1]);
                        end else if (a_reg[2] > 0) begin
                            cx_reg <= (CW+2)'(a_reg[2]);
                            cy_reg <= (CW+2)'(a_reg[0]);
                            r0mode_reg <= 1'b0;
                            r0fix_reg  <= '0;
                        end else if (a_reg[2] < 0) begin
                            cx_reg <= -(CW+2)'(a_reg[2]);
                            cy_reg <= -(CW+2)'(a_reg[0]);
                            r0mode_reg <= 1'b0;
                            r0fix_reg  <= (a_reg[0] > 0) ? PI_F : -PI_F;
                        end else begin
                            cx_reg <= (a_reg[0] > 0) ? (CW+2)'(a_reg[0]) : -(CW+2)'(a_reg[0]);
                            cy_reg <= '0;
                            r0mode_reg <= 1'b1;
                            r0fix_reg  <= (a_reg[0] > 0) ? (PI_F + (PI_F >>> 1))
                                                        : -(PI_F + (PI_F >>> 1));
                        end
                    end else if (int'(ci_reg) < NSTEP) begin
                        if (cy_reg >= 0) begin
                            cx_reg <= cx_reg + dxs;
                            cy_reg <= cy_reg - dys;
                            cz_reg <= cz_reg + (CW+2)'(tstep);
                        end else begin
                            cx_reg <= cx_reg - dxs;
                            cy_reg <= cy_reg + dys;
                            cz_reg <= cz_reg - (CW+2)'(tstep);
                        end
                        ci_reg <= ci_reg + 1'b1;
                    end else if (cmd.op == CMD_ROLL) begin
                        roll_reg <= r0mode_reg ? -r0fix_reg : -(CW'(cz_reg) + r0fix_reg);
                        mag_reg  <= cx_reg;
                    end else begin
                        pitch_reg <= CW'(cz_reg);
                    end
                end
                CMD_MAG: begin
                    if (cmd.start) begin
                        magp_reg <= 64'(mag_reg) * 64'(INVK_Q30);
                    end else begin
                        magp_reg <= (magp_reg + (64'sd1 <<< 29)) >>> 30;
                    end
                end
                CMD_APPLY: begin
                    if (cmd.start) begin
                        acnt_reg <= '0;
                    end else begin
                        acnt_reg <= acnt_reg + 1'b1;
                    end
                    if (!cmd.start && apply_en_reg) begin
                        case (apply_sel_reg)
                            2'd0: px_reg <= sat_add_w(px_reg, delta);
                            2'd1: py_reg <= sat_add_w(py_reg, delta);
                            default: pz_reg <= sat_add_w(pz_reg, delta);
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Multiply stage of the rule engine; the product is registered and used in the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apply_en_reg <= 1'b0;
        end else begin
            apply_en_reg  <= (cmd.op == CMD_APPLY) && apply_en && (acnt_reg != 2'd3)
                             && !(cmd.start);
            apply_neg_reg <= apply_neg;
            apply_sel_reg <= acnt_reg;
            prod_reg      <= (2*CW+4)'(apply_c) * (2*CW+4)'(apply_v);
        end
    end

    assign m_pos_x = px_reg;
    assign m_pos_y = py_reg;
    assign m_pos_z = pz_reg;
    assign m_mode  = mode_reg;
endmodule

[rtl/core/tilt_to_position_tracker_unit.sv]
// Tilt-to-position tracker.
// The input channel (s_valid/s_ready) takes one request: opcode 0 carries a
// raw accelerometer sample, opcode 1 a controller button word.
// Each request yields exactly one result on the m_ channel: the tracked
// position in Q16.16 and the current mode.
// For a sample, a shift-subtract divider calibrates all three axes, one CORDIC
// unit runs roll and pitch, the magnitude is scaled, and the three dead-zone
// rules share one multiplier. A button word, or a sample with a zero
// calibration span, answers without the divider; a sample with a null vector
// answers once the divider is through.
// One request is in flight at a time; s_ready is low until the result is taken.
// The result is held in registers while m_ready is low.
// Calibration registers are written through cfg_we, cfg_idx and cfg_data; the
// user must do so only while the block is idle, which the block does not enforce.
// Synchronous reset clears position and mode and loads the default
// calibration of 128 for zero g and 154 for one g.
module tilt_to_position_tracker_unit #(
    parameter int FRAC_BITS    = ttp_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ttp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ttp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ttp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [7:0]                     s_raw_x,
    input  logic [7:0]                     s_raw_y,
    input  logic [7:0]                     s_raw_z,
    input  logic [12:0]                    s_buttons,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_pos_x,
    output logic signed [31:0]             m_pos_y,
    output logic signed [31:0]             m_pos_z,
    output logic [1:0]                     m_mode
);
    import ttp_pkg::*;

    localparam int DIV_STEPS = 9 + FRAC_BITS;

    ttp_cmd_t  cmd;
    ttp_stat_t stat;

    ttp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS), .DIV_STEPS(DIV_STEPS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .stat(stat)
    );

    ttp_datapath #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS),
                   .DIV_STEPS(DIV_STEPS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .s_opcode(s_opcode), .s_raw_x(s_raw_x), .s_raw_y(s_raw_y),
        .s_raw_z(s_raw_z), .s_buttons(s_buttons),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_pos_z(m_pos_z), .m_mode(m_mode)
    );
endmodule

[sim/tilt_to_position_tracker_unit_tb.sv]
module tilt_to_position_tracker_unit_tb;
    import ttp_pkg::*;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam int STALL_LIMIT = 5000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_BUTTONS = 1'b1;

    localparam logic [12:0] BTN_TWO   = 13'h0001;
    localparam logic [12:0] BTN_ONE   = 13'h0002;
    localparam logic [12:0] BTN_B     = 13'h0004;
    localparam logic [12:0] BTN_A     = 13'h0008;
    localparam logic [12:0] BTN_MINUS = 13'h0010;
    localparam logic [12:0] BTN_HOME  = 13'h0080;
    localparam logic [12:0] BTN_LEFT  = 13'h0100;
    localparam logic [12:0] BTN_RIGHT = 13'h0200;
    localparam logic [12:0] BTN_DOWN  = 13'h0400;
    localparam logic [12:0] BTN_UP    = 13'h0800;
    localparam logic [12:0] BTN_PLUS  = 13'h1000;

    localparam longint PI_RAD = 64'sd3373259426;
    localparam longint K002 = 21474836;
    localparam longint K003 = 32212255;
    localparam longint K020 = 214748365;
    localparam longint GAIN_INV = 652032875;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [1:0] mode;
    } track_state_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic s_opcode;
    logic [7:0] s_raw_x;
    logic [7:0] s_raw_y;
    logic [7:0] s_raw_z;
    logic [12:0] s_buttons;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_pos_z;
    logic [1:0] m_mode;

    tilt_to_position_tracker_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_raw_x(s_raw_x), .s_raw_y(s_raw_y), .s_raw_z(s_raw_z),
        .s_buttons(s_buttons),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_pos_z(m_pos_z), .m_mode(m_mode)
    );

    track_state_t tracked;
    logic [7:0] zero_cal [3];
    logic [7:0] one_cal [3];
    track_state_t pending_positions [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int mismatches;
    int stall_count;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint to_frac(longint c);
        return (c + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    function automatic longint scale_round(longint c, longint v);
        return (c * v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [31:0] add_sat(logic signed [31:0] p, longint d);
        longint s;
        s = longint'(p) + d;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic longint cordic_angle(longint x, longint y, output longint mag);
        longint atan_tab [24];
        longint z, dx, dy, t;
        atan_tab = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
                     16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                     131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            t = to_frac(atan_tab[i]);
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += t;
            end else begin
                x -= dx; y += dy; z -= t;
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint g_of(logic [7:0] raw, int axis);
        longint num, den, q, lim;
        num = longint'(raw) - longint'(zero_cal[axis]);
        den = longint'(one_cal[axis]) - longint'(zero_cal[axis]);
        q = (num * (longint'(1) << FRAC)) / den;
        lim = longint'(8) << FRAC;
        if (q > lim - 1) q = lim - 1;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    task automatic track_sample(logic [7:0] rx, logic [7:0] ry, logic [7:0] rz);
        longint ax, ay, az, r0, roll, pitch, mag, r, unused;
        longint pi_f, half, c002, c003, c020;
        pi_f = to_frac(PI_RAD);
        half = longint'(1) << (FRAC - 1);
        c002 = to_frac(K002);
        c003 = to_frac(K003);
        c020 = to_frac(K020);
        for (int k = 0; k < 3; k++)
            if (one_cal[k] == zero_cal[k]) return;
        ax = g_of(rx, 0);
        ay = g_of(ry, 1);
        az = g_of(rz, 2);
        if (ax == 0 && az == 0) return;
        if (az > 0) begin
            r0 = cordic_angle(az, ax, mag);
        end else if (az < 0) begin
            r0 = cordic_angle(-az, -ax, mag);
            r0 += (ax > 0) ? pi_f : -pi_f;
        end else begin
            void'(cordic_angle(ax > 0 ? ax : -ax, 0, mag));
            r0 = (ax > 0) ? (pi_f + (pi_f >>> 1)) : -(pi_f + (pi_f >>> 1));
        end
        roll = -r0;
        r = (mag * GAIN_INV + (longint'(1) << 29)) >>> 30;
        pitch = cordic_angle(r, ay, unused);
        if (roll > half) tracked.px = add_sat(tracked.px, -scale_round(c002, roll - half));
        else if (roll < -half) tracked.px = add_sat(tracked.px, -scale_round(c002, roll + half));
        if (pitch > half) tracked.py = add_sat(tracked.py, -scale_round(c003, pitch - half));
        else if (pitch < -half) tracked.py = add_sat(tracked.py, -scale_round(c003, pitch + half));
        if (ax > c020) tracked.pz = add_sat(tracked.pz, scale_round(c002, ax - c020));
        else if (ax < -c020) tracked.pz = add_sat(tracked.pz, scale_round(c002, ax + c020));
    endtask

    task automatic track_buttons(logic [12:0] b);
        longint step;
        step = to_frac(K020);
        if (b & BTN_UP) tracked.py = add_sat(tracked.py, step);
        if (b & BTN_DOWN) tracked.py = add_sat(tracked.py, -step);
        if (b & BTN_RIGHT) tracked.px = add_sat(tracked.px, step);
        if (b & BTN_LEFT) tracked.px = add_sat(tracked.px, -step);
        if (b & BTN_PLUS) tracked.pz = add_sat(tracked.pz, step);
        if (b & BTN_MINUS) tracked.pz = add_sat(tracked.pz, -step);
        if (b & BTN_A) tracked.mode = MODE_A;
        if (b & BTN_B) tracked.mode = MODE_B;
        if (b & BTN_HOME) tracked.mode = MODE_NONE;
        if (b & BTN_ONE) tracked.mode = MODE_ROT;
        if (b & BTN_TWO) tracked.mode = MODE_NONE;
    endtask

    task automatic send_request(logic op, logic [7:0] rx, logic [7:0] ry, logic [7:0] rz,
                                logic [12:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_raw_x <= rx;
        s_raw_y <= ry;
        s_raw_z <= rz;
        s_buttons <= b;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_SAMPLE) track_sample(rx, ry, rz);
        else track_buttons(b);
        pending_positions.push_back(tracked);
    endtask

    task automatic send_random_sample();
        send_request(OP_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom), 13'($urandom));
    endtask

    task automatic send_random_buttons();
        logic [12:0] b;
        b = 13'($urandom);
        if ($urandom_range(1)) b &= 13'($urandom);
        send_request(OP_BUTTONS, 8'($urandom), 8'($urandom), 8'($urandom), b);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        s_valid <= 1'b0;
        wait (pending_positions.size() == 0);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx < REG_ONE_X) zero_cal[idx] = val;
        else one_cal[idx - REG_ONE_X] = val;
    endtask

    task automatic set_calibration(logic [7:0] z0, logic [7:0] z1, logic [7:0] z2,
                                   logic [7:0] o0, logic [7:0] o1, logic [7:0] o2);
        write_reg(REG_ZERO_X, z0);
        write_reg(REG_ZERO_Y, z1);
        write_reg(REG_ZERO_Z, z2);
        write_reg(REG_ONE_X, o0);
        write_reg(REG_ONE_Y, o1);
        write_reg(REG_ONE_Z, o2);
    endtask

    task automatic random_calibration();
        logic [7:0] z [3];
        logic [7:0] o [3];
        int span;
        for (int k = 0; k < 3; k++) begin
            z[k] = 8'($urandom_range(40, 215));
            span = $urandom_range(1, 40);
            o[k] = $urandom_range(1) ? z[k] + 8'(span) : z[k] - 8'(span);
        end
        set_calibration(z[0], z[1], z[2], o[0], o[1], o[2]);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        track_state_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_positions.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_positions.pop_front();
                if (m_pos_x !== want.px) report_mismatch("pos_x", m_pos_x, want.px);
                if (m_pos_y !== want.py) report_mismatch("pos_y", m_pos_y, want.py);
                if (m_pos_z !== want.pz) report_mismatch("pos_z", m_pos_z, want.pz);
                if (m_mode !== want.mode) report_mismatch("mode", m_mode, want.mode);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic test_buttons();
        logic [12:0] singles [11];
        singles = '{BTN_UP, BTN_DOWN, BTN_RIGHT, BTN_LEFT, BTN_PLUS, BTN_MINUS,
                    BTN_A, BTN_B, BTN_HOME, BTN_ONE, BTN_TWO};
        foreach (singles[i]) send_request(OP_BUTTONS, 8'hff, 8'h00, 8'hff, singles[i]);
        send_request(OP_BUTTONS, 8'h00, 8'hff, 8'h00, 13'h1fff);
        send_request(OP_BUTTONS, 8'h00, 8'h00, 8'h00, BTN_A | BTN_B | BTN_ONE);
        send_request(OP_BUTTONS, 8'h00, 8'h00, 8'h00, 13'h0000);
    endtask

    task automatic test_samples();
        send_request(OP_SAMPLE, 8'd128, 8'd200, 8'd128, 13'h1fff);
        send_request(OP_SAMPLE, 8'd160, 8'd140, 8'd128, 13'h0000);
        send_request(OP_SAMPLE, 8'd90, 8'd110, 8'd128, 13'h0000);
        send_request(OP_SAMPLE, 8'd200, 8'd128, 8'd100, 13'h0000);
        send_request(OP_SAMPLE, 8'd60, 8'd128, 8'd100, 13'h0000);
        send_request(OP_SAMPLE, 8'd128, 8'd128, 8'd100, 13'h0000);
        send_request(OP_SAMPLE, 8'd255, 8'd255, 8'd255, 13'h0000);
        send_request(OP_SAMPLE, 8'd0, 8'd0, 8'd0, 13'h0000);
        send_request(OP_SAMPLE, 8'd140, 8'd0, 8'd154, 13'h0000);
    endtask

    task automatic test_calibration_extremes();
        set_calibration(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_request(OP_SAMPLE, 8'd255, 8'd0, 8'd128, 13'h0000);
        send_request(OP_SAMPLE, 8'd10, 8'd255, 8'd0, 13'h0000);
        set_calibration(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_request(OP_SAMPLE, 8'd0, 8'd100, 8'd200, 13'h0000);
        set_calibration(8'd100, 8'd100, 8'd100, 8'd101, 8'd99, 8'd101);
        send_request(OP_SAMPLE, 8'd255, 8'd0, 8'd0, 13'h0000);
        send_request(OP_SAMPLE, 8'd0, 8'd255, 8'd255, 13'h0000);
        set_calibration(8'd128, 8'd128, 8'd128, 8'd154, 8'd154, 8'd128);
        send_request(OP_SAMPLE, 8'd200, 8'd60, 8'd30, 13'h0000);
        send_request(OP_BUTTONS, 8'd0, 8'd0, 8'd0, BTN_UP | BTN_B);
    endtask

    task automatic test_backpressure();
        s_valid <= 1'b0;
        wait (pending_positions.size() == 0);
        @(posedge aclk);
        hold_cycles <= 400;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(1)) send_random_sample();
            else send_random_buttons();
        end
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 99) random_calibration();
            if ($urandom_range(99) < 60) send_random_sample();
            else send_random_buttons();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_opcode = 1'b0;
        s_raw_x = '0;
        s_raw_y = '0;
        s_raw_z = '0;
        s_buttons = '0;
        m_ready = 1'b0;
        hold_cycles = 0;
        mismatches = 0;
        stall_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        tracked = '0;
        for (int k = 0; k < 3; k++) begin
            zero_cal[k] = 8'd128;
            one_cal[k] = 8'd154;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_buttons();
        test_samples();
        test_calibration_extremes();
        set_calibration(8'd128, 8'd128, 8'd128, 8'd154, 8'd154, 8'd154);

        send_idle_pct = 12;
        recv_idle_pct = 66;
        test_backpressure();
        test_random_traffic(500);
        send_idle_pct = 66;
        recv_idle_pct = 12;
        test_random_traffic(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(500);

        s_valid <= 1'b0;
        wait (pending_positions.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
